// ----- rtl/mste_pkg.sv -----
package mste_pkg;

    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = 6;

    localparam logic [15:0] TYPE_SYN = 16'h0000;
    localparam logic [15:0] TYPE_KEY = 16'h0001;
    localparam logic [15:0] TYPE_ABS = 16'h0003;

    localparam logic [15:0] CODE_SYNC_FRAME  = 16'h0000;
    localparam logic [15:0] CODE_BTN_FIRST   = 16'h0110;
    localparam logic [15:0] CODE_BTN_LAST    = 16'h0112;
    localparam logic [15:0] CODE_MT_SLOT_SEL = 16'h002f;
    localparam logic [15:0] ABS_MT_TRACK     = 16'h0039;
    localparam logic [15:0] ABS_MT_POS_X     = 16'h0035;
    localparam logic [15:0] ABS_MT_POS_Y     = 16'h0036;
    localparam logic [15:0] ABS_MT_PRESS     = 16'h003a;
    localparam logic [15:0] ABS_X            = 16'h0000;
    localparam logic [15:0] ABS_Y            = 16'h0001;
    localparam logic [15:0] CODE_ST_PRESS    = 16'h0018;

    localparam logic [2:0] REG_ENABLE  = 3'd0;
    localparam logic [2:0] REG_MT_MODE = 3'd1;
    localparam logic [2:0] REG_BP_MODE = 3'd2;
    localparam logic [2:0] REG_X_OFS   = 3'd3;
    localparam logic [2:0] REG_Y_OFS   = 3'd4;

    typedef enum logic [2:0] {
        KIND_UP     = 3'd0,
        KIND_DOWN   = 3'd1,
        KIND_MOTION = 3'd2,
        KIND_PRESS  = 3'd3,
        KIND_CLICK  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        FLD_ACTIVE,
        FLD_X,
        FLD_Y,
        FLD_PRESS
    } field_t;

    typedef struct packed {
        logic               now_active;
        logic signed [31:0] now_x;
        logic signed [31:0] now_y;
        logic        [15:0] now_pressure;
        logic               prev_active;
        logic signed [31:0] prev_x;
        logic signed [31:0] prev_y;
        logic        [15:0] prev_pressure;
    } slot_t;

    typedef struct packed {
        logic        en;
        field_t      fld;
        logic [31:0] data;
    } wr_t;

    typedef struct packed {
        kind_t              kind;
        logic        [3:0]  slot;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic        [15:0] p;
        logic        [1:0]  click;
        logic               last;
    } res_t;

endpackage

// ----- rtl/mste_cell.sv -----
module mste_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift,
    input  logic           sel,
    input  mste_pkg::wr_t  wr,
    input  mste_pkg::slot_t nbr,
    output mste_pkg::slot_t st
);

    mste_pkg::slot_t st_reg;
    mste_pkg::slot_t st_next;

    always_comb
    begin
        st_next = st_reg;
        if (shift)
        begin
            st_next = nbr;
        end
        else if (wr.en && sel)
        begin
            case (wr.fld)
                mste_pkg::FLD_ACTIVE: st_next.now_active   = wr.data[0];
                mste_pkg::FLD_X:      st_next.now_x        = $signed(wr.data);
                mste_pkg::FLD_Y:      st_next.now_y        = $signed(wr.data);
                mste_pkg::FLD_PRESS:  st_next.now_pressure = wr.data[15:0];
                default:              st_next = st_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    assign st = st_reg;

endmodule

// ----- rtl/multitouch_slot_event_tracker.sv -----
// Channel   | Direction | Handshake                   | Payload
// event     | in        | event_valid / event_ready   | event_type, event_code, event_value
// result    | out       | result_valid / result_ready | result_kind .. last_of_run
// config    | in        | cfg_we                      | cfg_index, cfg_data
//
// A transfer is taken in idle while the output register is free.
// A report sync rotates the ring of slot cells past the head, then passes through a flush state,
// up to two results per slot through a one-deep hold stage.
// Reset puts all slot cells and control registers in their reset state at once (MT mode set); no clearing pass.
// A stalled result side holds the walk; events are refused until the walk and flush end.
module multitouch_slot_event_tracker #(
    parameter int NUM_SLOTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               event_valid,
    output logic               event_ready,
    input  logic        [15:0] event_type,
    input  logic        [15:0] event_code,
    input  logic signed [31:0] event_value,
    output logic               result_valid,
    input  logic               result_ready,
    output logic        [2:0]  result_kind,
    output logic        [3:0]  slot_id,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic        [15:0] contact_pressure,
    output logic        [1:0]  click_state,
    output logic               last_of_run,
    input  logic               cfg_we,
    input  logic        [2:0]  cfg_index,
    input  logic        [15:0] cfg_data
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic        enable_reg;
    logic        mt_mode_reg;
    logic        bp_mode_reg;
    logic [15:0] x_ofs_reg;
    logic [15:0] y_ofs_reg;

    mste_pkg::state_t state_reg, state_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic             phase_reg, phase_next;
    logic [mste_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    mste_pkg::res_t   hold_reg, hold_next;
    logic             hold_valid_reg, hold_valid_next;
    mste_pkg::res_t   out_reg, out_next;
    logic             out_valid_reg, out_valid_next;
    logic [IW-1:0]    sel_reg, sel_next;
    logic             oor_reg, oor_next;

    logic             shift;
    mste_pkg::wr_t    wr;
    mste_pkg::slot_t  cell_st  [NUM_SLOTS];
    mste_pkg::slot_t  cell_nbr [NUM_SLOTS];
    mste_pkg::slot_t  head;
    mste_pkg::slot_t  tail_in;

    logic             out_free;
    logic             up_c, down_c, mot_c, pr_c;
    logic             has_first, has_second;
    mste_pkg::res_t   first_res, second_res;
    logic signed [32:0] sum_x, sum_y;
    logic [31:0]      sat_x, sat_y;
    logic [15:0]      sat_p;
    logic [1:0]       click_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            mt_mode_reg <= 1'b1;
            bp_mode_reg <= 1'b0;
            x_ofs_reg   <= '0;
            y_ofs_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mste_pkg::REG_ENABLE:  enable_reg  <= cfg_data[0];
                mste_pkg::REG_MT_MODE: mt_mode_reg <= cfg_data[0];
                mste_pkg::REG_BP_MODE: bp_mode_reg <= cfg_data[0];
                mste_pkg::REG_X_OFS:   x_ofs_reg   <= cfg_data;
                mste_pkg::REG_Y_OFS:   y_ofs_reg   <= cfg_data;
                default:               enable_reg  <= enable_reg;
            endcase
        end
    end

    assign head = cell_st[0];

    always_comb
    begin
        tail_in               = head;
        tail_in.prev_active   = head.now_active;
        tail_in.prev_x        = head.now_x;
        tail_in.prev_y        = head.now_y;
        tail_in.prev_pressure = head.now_pressure;
    end

    for (genvar k = 0; k < NUM_SLOTS; k++)
    begin : g_cell
        if (k == NUM_SLOTS - 1)
        begin : g_tail
            assign cell_nbr[k] = tail_in;
        end
        else
        begin : g_mid
            assign cell_nbr[k] = cell_st[k+1];
        end
        mste_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .sel   (sel_reg == IW'(k)),
            .wr    (wr),
            .nbr   (cell_nbr[k]),
            .st    (cell_st[k])
        );
    end

    assign sum_x = $signed({event_value[31], event_value}) + $signed({17'b0, x_ofs_reg});
    assign sum_y = $signed({event_value[31], event_value}) + $signed({17'b0, y_ofs_reg});
    assign sat_x = (sum_x[32:31] == 2'b01) ? 32'h7fff_ffff : sum_x[31:0];
    assign sat_y = (sum_y[32:31] == 2'b01) ? 32'h7fff_ffff : sum_y[31:0];
    assign sat_p = event_value[31] ? 16'h0000 :
                   (|event_value[30:16]) ? 16'hffff : event_value[15:0];
    assign click_v = event_value[31] ? 2'd0 :
                     ((|event_value[30:2]) || (event_value[1:0] == 2'd3)) ? 2'd2 :
                     event_value[1:0];

    assign up_c   = head.prev_active && !head.now_active;
    assign down_c = !head.prev_active && head.now_active;
    assign mot_c  = (head.prev_x != head.now_x) || (head.prev_y != head.now_y);
    assign pr_c   = head.prev_pressure != head.now_pressure;

    always_comb
    begin
        first_res       = '0;
        first_res.slot  = 4'(idx_reg);
        second_res      = '0;
        second_res.slot = 4'(idx_reg);
        second_res.kind = mste_pkg::KIND_PRESS;
        second_res.p    = head.now_pressure;
        has_first       = 1'b1;
        has_second      = 1'b0;
        if (up_c)
        begin
            first_res.kind = mste_pkg::KIND_UP;
        end
        else if (down_c)
        begin
            first_res.kind = mste_pkg::KIND_DOWN;
            first_res.x    = head.now_x;
            first_res.y    = head.now_y;
            first_res.p    = head.now_pressure;
        end
        else if (mot_c)
        begin
            first_res.kind = mste_pkg::KIND_MOTION;
            first_res.x    = head.now_x;
            first_res.y    = head.now_y;
            has_second     = pr_c;
        end
        else if (pr_c)
        begin
            first_res = second_res;
        end
        else
        begin
            has_first = 1'b0;
        end
    end

    assign out_free    = !out_valid_reg || result_ready;
    assign event_ready = (state_reg == mste_pkg::ST_IDLE) && out_free;

    always_comb
    begin
        logic gen;
        mste_pkg::res_t new_res;
        state_next      = state_reg;
        idx_next        = idx_reg;
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        sel_next        = sel_reg;
        oor_next        = oor_reg;
        shift           = 1'b0;
        wr              = '0;
        gen             = 1'b0;
        new_res         = phase_reg ? second_res : first_res;
        case (state_reg)
            mste_pkg::ST_IDLE:
            begin
                if (event_valid && event_ready && enable_reg)
                begin
                    case (event_type)
                        mste_pkg::TYPE_SYN:
                        begin
                            if (event_code == mste_pkg::CODE_SYNC_FRAME)
                            begin
                                state_next = mste_pkg::ST_WALK;
                                idx_next   = '0;
                                phase_next = 1'b0;
                                cnt_next   = '0;
                            end
                        end
                        mste_pkg::TYPE_KEY:
                        begin
                            if (bp_mode_reg && event_code >= mste_pkg::CODE_BTN_FIRST &&
                                event_code <= mste_pkg::CODE_BTN_LAST)
                            begin
                                out_next       = '0;
                                out_next.kind  = mste_pkg::KIND_CLICK;
                                out_next.click = click_v;
                                out_next.last  = 1'b1;
                                out_valid_next = 1'b1;
                            end
                        end
                        mste_pkg::TYPE_ABS:
                        begin
                            if (mt_mode_reg && event_code == mste_pkg::CODE_MT_SLOT_SEL)
                            begin
                                if (!event_value[31] &&
                                    $unsigned(event_value) < 32'(NUM_SLOTS))
                                begin
                                    sel_next = IW'(event_value);
                                    oor_next = 1'b0;
                                end
                                else
                                begin
                                    oor_next = 1'b1;
                                end
                            end
                            else if (!oor_reg)
                            begin
                                if (mt_mode_reg)
                                begin
                                    case (event_code)
                                        mste_pkg::ABS_MT_TRACK:
                                        begin
                                            wr.en   = 1'b1;
                                            wr.fld  = mste_pkg::FLD_ACTIVE;
                                            wr.data = {31'b0, event_value != -32'sd1};
                                        end
                                        mste_pkg::ABS_MT_POS_X:
                                        begin
                                            wr.en = 1'b1; wr.fld = mste_pkg::FLD_X;
                                            wr.data = sat_x;
                                        end
                                        mste_pkg::ABS_MT_POS_Y:
                                        begin
                                            wr.en = 1'b1; wr.fld = mste_pkg::FLD_Y;
                                            wr.data = sat_y;
                                        end
                                        mste_pkg::ABS_MT_PRESS:
                                        begin
                                            wr.en = 1'b1; wr.fld = mste_pkg::FLD_PRESS;
                                            wr.data = {16'b0, sat_p};
                                        end
                                        default: wr.en = 1'b0;
                                    endcase
                                end
                                else
                                begin
                                    case (event_code)
                                        mste_pkg::ABS_X:
                                        begin
                                            wr.en = 1'b1; wr.fld = mste_pkg::FLD_X;
                                            wr.data = sat_x;
                                        end
                                        mste_pkg::ABS_Y:
                                        begin
                                            wr.en = 1'b1; wr.fld = mste_pkg::FLD_Y;
                                            wr.data = sat_y;
                                        end
                                        mste_pkg::CODE_ST_PRESS:
                                        begin
                                            wr.en = 1'b1; wr.fld = mste_pkg::FLD_PRESS;
                                            wr.data = {16'b0, sat_p};
                                        end
                                        default: wr.en = 1'b0;
                                    endcase
                                end
                            end
                        end
                        default: state_next = mste_pkg::ST_IDLE;
                    endcase
                end
            end
            mste_pkg::ST_WALK:
            begin
                gen = (phase_reg ? has_second : has_first) &&
                      (cnt_reg < mste_pkg::CNT_W'(mste_pkg::MAX_RESULTS));
                if (!(gen && hold_valid_reg && !out_free))
                begin
                    if (gen)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_next       = hold_reg;
                            out_next.last  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        hold_next       = new_res;
                        hold_valid_next = 1'b1;
                        cnt_next        = cnt_reg + 1'b1;
                    end
                    if (!phase_reg && has_second)
                    begin
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        shift      = 1'b1;
                        idx_next   = idx_reg + 1'b1;
                        if (idx_reg == IW'(NUM_SLOTS - 1))
                        begin
                            state_next = mste_pkg::ST_FLUSH;
                        end
                    end
                end
            end
            mste_pkg::ST_FLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = mste_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = hold_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = mste_pkg::ST_IDLE;
                end
            end
            default: state_next = mste_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mste_pkg::ST_IDLE;
            idx_reg        <= '0;
            phase_reg      <= 1'b0;
            cnt_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            sel_reg        <= '0;
            oor_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            sel_reg        <= sel_next;
            oor_reg        <= oor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign result_valid     = out_valid_reg;
    assign result_kind      = out_reg.kind;
    assign slot_id          = out_reg.slot;
    assign pos_x            = out_reg.x;
    assign pos_y            = out_reg.y;
    assign contact_pressure = out_reg.p;
    assign click_state      = out_reg.click;
    assign last_of_run      = out_reg.last;

endmodule

// ----- rtl/mste_checker.sv -----
module mste_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               event_ready,
    input logic               result_valid,
    input logic               result_ready,
    input logic        [2:0]  result_kind,
    input logic        [3:0]  slot_id,
    input logic signed [31:0] pos_x,
    input logic               last_of_run
);

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    a_no_event_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !event_ready)
        else $error("event taken while result stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_kind <= mste_pkg::KIND_CLICK)
        else $error("bad result kind");

    a_click_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == mste_pkg::KIND_CLICK |-> slot_id == 4'd0 && last_of_run)
        else $error("malformed click");

    a_up_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == mste_pkg::KIND_UP |-> pos_x == 32'sd0)
        else $error("touch up carries position");

endmodule

bind multitouch_slot_event_tracker mste_checker u_mste_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .event_ready  (event_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_kind  (result_kind),
    .slot_id      (slot_id),
    .pos_x        (pos_x),
    .last_of_run  (last_of_run)
);

// ----- tb/multitouch_slot_event_tracker_test.sv -----
`timescale 1ns / 1ps

module multitouch_slot_event_tracker_test;

    localparam int SLOTS = 16;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [15:0] CODE_BTN_INNER  = 16'h0111;
    localparam logic [15:0] CODE_KEY_PAST   = 16'h0113;
    localparam logic [15:0] CODE_SYNC_OTHER = 16'h0002;
    localparam logic [2:0]  REG_UNUSED      = 3'd6;

    typedef struct {
        logic [2:0]         kind;
        logic [3:0]         slot;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        p;
        logic [1:0]         click;
        logic               last;
    } touch_res_t;

    class touch_scoreboard;
        bit                 en;
        bit                 mt;
        bit                 bp;
        logic [15:0]        xofs;
        logic [15:0]        yofs;
        bit                 cur_act[SLOTS];
        logic signed [31:0] cur_x[SLOTS];
        logic signed [31:0] cur_y[SLOTS];
        logic [15:0]        cur_p[SLOTS];
        bit                 old_act[SLOTS];
        logic signed [31:0] old_x[SLOTS];
        logic signed [31:0] old_y[SLOTS];
        logic [15:0]        old_p[SLOTS];
        int                 sel;
        bit                 bad_slot;
        touch_res_t         pending[$];
        int                 errors;

        function new();
            en = 0;
            mt = 1;
            bp = 0;
            xofs = 0;
            yofs = 0;
            sel = 0;
            bad_slot = 0;
            errors = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                cur_act[i] = 0; cur_x[i] = 0; cur_y[i] = 0; cur_p[i] = 0;
                old_act[i] = 0; old_x[i] = 0; old_y[i] = 0; old_p[i] = 0;
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                mste_pkg::REG_ENABLE:  en = data[0];
                mste_pkg::REG_MT_MODE: mt = data[0];
                mste_pkg::REG_BP_MODE: bp = data[0];
                mste_pkg::REG_X_OFS:   xofs = data;
                mste_pkg::REG_Y_OFS:   yofs = data;
                default: ;
            endcase
        endfunction

        function logic signed [31:0] offset_pos(logic signed [31:0] v, logic [15:0] ofs);
            longint s;
            s = longint'(v) + longint'(ofs);
            return (s > 64'sd2147483647) ? 32'sh7fffffff : v + $signed({16'd0, ofs});
        endfunction

        function logic [15:0] clamp_press(logic signed [31:0] v);
            if (v < 0)
                return 16'd0;
            if (v > 65535)
                return 16'hffff;
            return v[15:0];
        endfunction

        function void add(int n, logic [2:0] k, int s, logic signed [31:0] x,
                          logic signed [31:0] y, logic [15:0] p, logic [1:0] c);
            touch_res_t r;
            if (n >= mste_pkg::MAX_RESULTS)
                return;
            r.kind = k; r.slot = s[3:0]; r.x = x; r.y = y; r.p = p; r.click = c; r.last = 0;
            pending.push_back(r);
        endfunction

        function void note_event(logic [15:0] t, logic [15:0] c, logic signed [31:0] v);
            int n0;
            bit ok;
            touch_res_t r;
            n0 = pending.size();
            if (!en)
                return;
            if (t == mste_pkg::TYPE_SYN)
            begin
                if (c == mste_pkg::CODE_SYNC_FRAME)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (old_act[i] && !cur_act[i])
                            add(pending.size() - n0, mste_pkg::KIND_UP, i, 0, 0, 0, 0);
                        else if (!old_act[i] && cur_act[i])
                            add(pending.size() - n0, mste_pkg::KIND_DOWN, i, cur_x[i],
                                cur_y[i], cur_p[i], 0);
                        else
                        begin
                            if (old_x[i] != cur_x[i] || old_y[i] != cur_y[i])
                                add(pending.size() - n0, mste_pkg::KIND_MOTION, i, cur_x[i],
                                    cur_y[i], 0, 0);
                            if (old_p[i] != cur_p[i])
                                add(pending.size() - n0, mste_pkg::KIND_PRESS, i, 0, 0,
                                    cur_p[i], 0);
                        end
                    end
                    old_act = cur_act; old_x = cur_x; old_y = cur_y; old_p = cur_p;
                end
            end
            else if (t == mste_pkg::TYPE_KEY)
            begin
                if (c >= mste_pkg::CODE_BTN_FIRST && c <= mste_pkg::CODE_BTN_LAST && bp)
                    add(0, mste_pkg::KIND_CLICK, 0, 0, 0, 0,
                        (v < 0) ? 2'd0 : (v > 2) ? 2'd2 : v[1:0]);
            end
            else if (t == mste_pkg::TYPE_ABS)
            begin
                ok = !bad_slot;
                if (mt)
                begin
                    if (c == mste_pkg::CODE_MT_SLOT_SEL)
                    begin
                        if (v >= 0 && v < SLOTS)
                        begin
                            sel = v;
                            bad_slot = 0;
                        end
                        else
                            bad_slot = 1;
                    end
                    else if (ok)
                    begin
                        if (c == mste_pkg::ABS_MT_TRACK)
                            cur_act[sel] = (v != -1);
                        else if (c == mste_pkg::ABS_MT_POS_X)
                            cur_x[sel] = offset_pos(v, xofs);
                        else if (c == mste_pkg::ABS_MT_POS_Y)
                            cur_y[sel] = offset_pos(v, yofs);
                        else if (c == mste_pkg::ABS_MT_PRESS)
                            cur_p[sel] = clamp_press(v);
                    end
                end
                else if (ok)
                begin
                    if (c == mste_pkg::ABS_X)
                        cur_x[sel] = offset_pos(v, xofs);
                    else if (c == mste_pkg::ABS_Y)
                        cur_y[sel] = offset_pos(v, yofs);
                    else if (c == mste_pkg::CODE_ST_PRESS)
                        cur_p[sel] = clamp_press(v);
                end
            end
            if (pending.size() > n0)
            begin
                r = pending[$];
                r.last = 1;
                pending[$] = r;
            end
        endfunction

        task check_result(touch_res_t got);
            touch_res_t w;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result", 0, got.kind);
                return;
            end
            w = pending.pop_front();
            if (got.kind !== w.kind)
                report_mismatch("result_kind", w.kind, got.kind);
            if (got.slot !== w.slot)
                report_mismatch("slot_id", w.slot, got.slot);
            if (got.x !== w.x)
                report_mismatch("pos_x", w.x, got.x);
            if (got.y !== w.y)
                report_mismatch("pos_y", w.y, got.y);
            if (got.p !== w.p)
                report_mismatch("contact_pressure", w.p, got.p);
            if (got.click !== w.click)
                report_mismatch("click_state", w.click, got.click);
            if (got.last !== w.last)
                report_mismatch("last_of_run", w.last, got.last);
        endtask

        task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
            $display("MISMATCH %s: expected %h got %h", what, want, got);
            errors++;
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               event_valid;
    logic               event_ready;
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [31:0] event_value;
    logic               result_valid;
    logic               result_ready;
    logic [2:0]         result_kind;
    logic [3:0]         slot_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        contact_pressure;
    logic [1:0]         click_state;
    logic               last_of_run;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;

    touch_scoreboard sb;
    int              cycles;
    int              sent;
    bit              quiet;
    bit              hold_off;
    bit              offering;

    multitouch_slot_event_tracker #(.NUM_SLOTS(SLOTS)) u_top (
        .clk(clk), .rst_n(rst_n),
        .event_valid(event_valid), .event_ready(event_ready),
        .event_type(event_type), .event_code(event_code), .event_value(event_value),
        .result_valid(result_valid), .result_ready(result_ready),
        .result_kind(result_kind), .slot_id(slot_id), .pos_x(pos_x), .pos_y(pos_y),
        .contact_pressure(contact_pressure), .click_state(click_state),
        .last_of_run(last_of_run),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        touch_res_t r;
        if (rst_n && result_valid && result_ready)
        begin
            r.kind = result_kind; r.slot = slot_id; r.x = pos_x; r.y = pos_y;
            r.p = contact_pressure; r.click = click_state; r.last = last_of_run;
            sb.check_result(r);
        end
    end

    initial
    begin
        result_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                result_ready <= 0;
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                result_ready <= 0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                result_ready <= 1;
            end
            else
                result_ready <= 1;
        end
    end

    task automatic stop_events();
        if (offering)
        begin
            event_valid <= 0;
            offering = 0;
        end
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [15:0] data);
        stop_events();
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we <= 0;
    endtask

    task automatic send_event(logic [15:0] t, logic [15:0] c, logic signed [31:0] v);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stop_events();
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        event_valid <= 1;
        offering = 1;
        event_type <= t;
        event_code <= c;
        event_value <= v;
        do
            @(posedge clk);
        while (!event_ready);
        sb.note_event(t, c, v);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        stop_events();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (2 * SLOTS + 8) @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return -1;
            2: return 32'sh7fffffff - $urandom_range(0, 3);
            3: return 32'sh80000000 + $urandom_range(0, 3);
            default: return $urandom_range(0, 4000);
        endcase
    endfunction

    task automatic send_frame();
        int n;
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++)
        begin
            send_event(mste_pkg::TYPE_ABS, mste_pkg::CODE_MT_SLOT_SEL,
                       $urandom_range(0, SLOTS - 1));
            if ($urandom_range(0, 2) == 0)
                send_event(mste_pkg::TYPE_ABS, mste_pkg::ABS_MT_TRACK,
                           $urandom_range(0, 3) == 0 ? -1 : $urandom_range(0, 999));
            send_event(mste_pkg::TYPE_ABS, mste_pkg::ABS_MT_POS_X, pick_value());
            if ($urandom_range(0, 1))
                send_event(mste_pkg::TYPE_ABS, mste_pkg::ABS_MT_POS_Y, pick_value());
            if ($urandom_range(0, 1))
                send_event(mste_pkg::TYPE_ABS, mste_pkg::ABS_MT_PRESS, pick_value());
        end
        send_event(mste_pkg::TYPE_SYN, mste_pkg::CODE_SYNC_FRAME, 0);
    endtask

    task automatic send_noise();
        logic [15:0] codes[12] = '{mste_pkg::CODE_MT_SLOT_SEL, mste_pkg::ABS_MT_TRACK,
                                    mste_pkg::ABS_MT_POS_X, mste_pkg::ABS_MT_POS_Y,
                                    mste_pkg::ABS_MT_PRESS, mste_pkg::ABS_X, mste_pkg::ABS_Y,
                                    mste_pkg::CODE_ST_PRESS, mste_pkg::CODE_BTN_FIRST,
                                    CODE_BTN_INNER, mste_pkg::CODE_BTN_LAST,
                                    mste_pkg::CODE_SYNC_FRAME};
        logic [15:0] t;
        logic [15:0] c;
        case ($urandom_range(0, 4))
            0: t = mste_pkg::TYPE_SYN;
            1: t = mste_pkg::TYPE_KEY;
            2, 3: t = mste_pkg::TYPE_ABS;
            default: t = 16'($urandom);
        endcase
        c = $urandom_range(0, 3) == 0 ? 16'($urandom) : codes[$urandom_range(0, 11)];
        send_event(t, c, $urandom_range(0, 1) ? pick_value() : $urandom_range(0, 20) - 3);
    endtask

    task automatic random_phase(int items, bit single);
        int start;
        start = sent;
        while (sent - start < items)
        begin
            if (single)
            begin
                case ($urandom_range(0, 3))
                    0: send_event(mste_pkg::TYPE_ABS, mste_pkg::ABS_X, pick_value());
                    1: send_event(mste_pkg::TYPE_ABS, mste_pkg::ABS_Y, pick_value());
                    2: send_event(mste_pkg::TYPE_ABS, mste_pkg::CODE_ST_PRESS, pick_value());
                    default: send_event(mste_pkg::TYPE_SYN, mste_pkg::CODE_SYNC_FRAME, 0);
                endcase
            end
            else if ($urandom_range(0, 3) != 0)
                send_frame();
            else
                send_noise();
        end
        stop_events();
    endtask

    initial
    begin
        sb = new();
        quiet = 0;
        hold_off = 0;
        offering = 0;
        sent = 0;
        rst_n = 0;
        event_valid = 0;
        event_type = 0;
        event_code = 0;
        event_value = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_event(mste_pkg::TYPE_SYN, mste_pkg::CODE_SYNC_FRAME, 0);
        write_cfg(mste_pkg::REG_ENABLE, 1);
        write_cfg(mste_pkg::REG_BP_MODE, 1);
        write_cfg(REG_UNUSED, 16'hffff);
        send_event(mste_pkg::TYPE_KEY, mste_pkg::CODE_BTN_FIRST, -5);
        send_event(mste_pkg::TYPE_KEY, CODE_BTN_INNER, 1);
        send_event(mste_pkg::TYPE_KEY, mste_pkg::CODE_BTN_LAST, 9);
        send_event(mste_pkg::TYPE_KEY, CODE_KEY_PAST, 1);
        for (int i = 0; i < SLOTS; i++)
        begin
            send_event(mste_pkg::TYPE_ABS, mste_pkg::CODE_MT_SLOT_SEL, i);
            send_event(mste_pkg::TYPE_ABS, mste_pkg::ABS_MT_TRACK, i);
        end
        send_event(mste_pkg::TYPE_ABS, mste_pkg::CODE_MT_SLOT_SEL, 0);
        send_event(mste_pkg::TYPE_ABS, mste_pkg::ABS_MT_POS_X, 32'sh7fffffff);
        send_event(mste_pkg::TYPE_ABS, mste_pkg::ABS_MT_POS_Y, 32'sh80000000);
        send_event(mste_pkg::TYPE_ABS, mste_pkg::ABS_MT_PRESS, 70000);
        send_event(mste_pkg::TYPE_ABS, mste_pkg::CODE_MT_SLOT_SEL, 16);
        send_event(mste_pkg::TYPE_ABS, mste_pkg::ABS_MT_POS_X, 5);
        send_event(mste_pkg::TYPE_ABS, mste_pkg::CODE_MT_SLOT_SEL, -1);
        send_event(mste_pkg::TYPE_SYN, CODE_SYNC_OTHER, 0);
        send_event(mste_pkg::TYPE_SYN, mste_pkg::CODE_SYNC_FRAME, 0);
        send_event(mste_pkg::TYPE_ABS, mste_pkg::CODE_MT_SLOT_SEL, 3);
        send_event(mste_pkg::TYPE_ABS, mste_pkg::ABS_MT_PRESS, -7);
        send_event(mste_pkg::TYPE_SYN, mste_pkg::CODE_SYNC_FRAME, 0);
        drain();

        write_cfg(mste_pkg::REG_X_OFS, 16'hffff);
        write_cfg(mste_pkg::REG_Y_OFS, 16'hffff);
        random_phase(80, 0);

        hold_off = 1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
            random_phase(30, 0);
        join
        drain();

        write_cfg(mste_pkg::REG_MT_MODE, 0);
        write_cfg(mste_pkg::REG_X_OFS, 16'd1234);
        write_cfg(mste_pkg::REG_Y_OFS, 16'd0);
        random_phase(60, 1);
        drain();

        write_cfg(mste_pkg::REG_ENABLE, 0);
        random_phase(15, 0);
        drain();

        write_cfg(mste_pkg::REG_ENABLE, 1);
        write_cfg(mste_pkg::REG_MT_MODE, 1);
        write_cfg(mste_pkg::REG_BP_MODE, 0);
        write_cfg(mste_pkg::REG_Y_OFS, 16'd77);
        random_phase(80, 0);
        drain();

        write_cfg(mste_pkg::REG_BP_MODE, 1);
        quiet = 1;
        random_phase(60, 0);
        drain();

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
